>>> rtl/sfq_pkg.sv
// Shared types and codes of the searchable FIFO queue.
package sfq_pkg;

    localparam int unsigned IO_VALUE_WIDTH = 32;
    localparam int unsigned OP_WIDTH       = 2;
    localparam int unsigned STATUS_WIDTH   = 2;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_LOOK = 2'd2,
        OP_DEL  = 2'd3
    } t_op;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_WRITE = 2'd1,
        CELL_SHIFT = 2'd2
    } t_cell_op;

endpackage

>>> rtl/sfq_cell.sv
// One queue cell: holds one entry, takes its neighbor's entry on a shift.
module sfq_cell
    import sfq_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32,
    parameter int unsigned IW          = 5,
    parameter int unsigned INDEX       = 0
) (
    input  logic                   i_clk,
    input  t_cell_op               i_op,
    input  logic [IW-1:0]          i_idx,
    input  logic [VALUE_WIDTH-1:0] i_key,
    input  logic [VALUE_WIDTH-1:0] i_next,
    output logic [VALUE_WIDTH-1:0] o_data,
    output logic                   o_hit
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [VALUE_WIDTH-1:0] r_data;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            CELL_WRITE: begin
                if (i_idx == MY_IDX) begin
                    r_data <= i_key;
                end
            end
            CELL_SHIFT: begin
                if (i_idx <= MY_IDX) begin
                    r_data <= i_next;
                end
            end
            CELL_HOLD: begin
                r_data <= r_data;
            end
            default: begin
                r_data <= r_data;
            end
        endcase
    end

    assign o_data = r_data;
    assign o_hit  = (i_idx == MY_IDX) && (r_data == i_key);

endmodule

>>> rtl/sfq_chain.sv
// Row of queue cells with the head tap and the probe hit.
module sfq_chain
    import sfq_pkg::*;
#(
    parameter int unsigned DEPTH       = 16,
    parameter int unsigned VALUE_WIDTH = 32,
    parameter int unsigned IW          = 5
) (
    input  logic                   i_clk,
    input  t_cell_op               i_op,
    input  logic [IW-1:0]          i_idx,
    input  logic [VALUE_WIDTH-1:0] i_key,
    output logic [VALUE_WIDTH-1:0] o_head,
    output logic                   o_hit
);

    logic [VALUE_WIDTH-1:0] w_data [DEPTH];
    logic [DEPTH-1:0]       w_hit;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_next;
        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_data[g];
        end else begin : g_mid
            assign w_next = w_data[g+1];
        end
        sfq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .IW          (IW),
            .INDEX       (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_op   (i_op),
            .i_idx  (i_idx),
            .i_key  (i_key),
            .i_next (w_next),
            .o_data (w_data[g]),
            .o_hit  (w_hit[g])
        );
    end

    assign o_head = w_data[0];
    assign o_hit  = |w_hit;

endmodule

>>> rtl/searchable_fifo_queue_top.sv
// Top level of the searchable FIFO queue: control, count and result register.
//
//  channel   dir  tdata              tuser        tlast
//  s_axis    in   value [31:0]       op [1:0]     -
//  m_axis    out  value_out [31:0]   status [1:0] -
//
//  Enqueue and dequeue complete at the transfer; the result is registered there.
//  Lookup and delete scan the chain from the head up to the first match (or the
//  entry count), one cell of the chain probed per cycle.
//  Reset clears the entry count and control; cell contents stay undefined.
//  A waiting result does not block a new transfer if it is taken in that cycle.
module searchable_fifo_queue_top
    import sfq_pkg::*;
#(
    parameter int unsigned DEPTH       = 16,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IO_VALUE_WIDTH-1:0] s_axis_tdata,  // value
    input  logic [OP_WIDTH-1:0]       s_axis_tuser,  // op
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [IO_VALUE_WIDTH-1:0] m_axis_tdata,  // value_out
    output logic [STATUS_WIDTH-1:0]   m_axis_tuser   // status
);

    localparam int unsigned IW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] FULL_COUNT = IW'(DEPTH);
    localparam logic [IW-1:0] ONE        = IW'(1);

    typedef enum logic {S_IDLE, S_SCAN} t_state;

    t_state                      r_state, n_state;
    logic [IW-1:0]               r_count, n_count;
    logic [IW-1:0]               r_idx, n_idx;
    logic [VALUE_WIDTH-1:0]      r_key, n_key;
    logic                        r_del, n_del;
    logic                        r_out_valid, n_out_valid;
    t_status                     r_out_status, n_out_status;
    logic [IO_VALUE_WIDTH-1:0]   r_out_data, n_out_data;

    t_cell_op                    w_cell_op;
    logic [IW-1:0]               w_cell_idx;
    logic [VALUE_WIDTH-1:0]      w_cell_key;
    logic [VALUE_WIDTH-1:0]      w_head;
    logic                        w_hit;
    logic                        w_accept;
    t_op                         w_op;
    logic [VALUE_WIDTH-1:0]      w_in_key;

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_op          = t_op'(s_axis_tuser);
    assign w_in_key      = VALUE_WIDTH'($signed(s_axis_tdata));

    sfq_chain #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .IW          (IW)
    ) u_chain (
        .i_clk  (i_clk),
        .i_op   (w_cell_op),
        .i_idx  (w_cell_idx),
        .i_key  (w_cell_key),
        .o_head (w_head),
        .o_hit  (w_hit)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_key        = r_key;
        n_del        = r_del;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        w_cell_op    = CELL_HOLD;
        w_cell_idx   = r_idx;
        w_cell_key   = r_key;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_op)
                        OP_ENQ: begin
                            n_out_valid = 1'b1;
                            n_out_data  = '0;
                            if (r_count == FULL_COUNT) begin
                                n_out_status = ST_FULL;
                            end else begin
                                w_cell_op    = CELL_WRITE;
                                w_cell_idx   = r_count;
                                w_cell_key   = w_in_key;
                                n_count      = r_count + ONE;
                                n_out_status = ST_OK;
                            end
                        end
                        OP_DEQ: begin
                            n_out_valid = 1'b1;
                            if (r_count != '0) begin
                                w_cell_op    = CELL_SHIFT;
                                w_cell_idx   = '0;
                                n_count      = r_count - ONE;
                                n_out_status = ST_OK;
                                n_out_data   = IO_VALUE_WIDTH'($signed(w_head));
                            end else begin
                                n_out_status = ST_EMPTY;
                                n_out_data   = '0;
                            end
                        end
                        OP_LOOK, OP_DEL: begin
                            n_state = S_SCAN;
                            n_key   = w_in_key;
                            n_idx   = '0;
                            n_del   = (w_op == OP_DEL);
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_idx == r_count) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_status = ST_EMPTY;
                    n_out_data   = '0;
                end else if (w_hit) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_data   = '0;
                    if (r_del) begin
                        w_cell_op = CELL_SHIFT;
                        n_count   = r_count - ONE;
                    end
                end else begin
                    n_idx = r_idx + ONE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_del       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_idx        <= n_idx;
            r_key        <= n_key;
            r_del        <= n_del;
            r_out_valid  <= n_out_valid;
            r_out_status <= n_out_status;
            r_out_data   <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count above depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_count))
        else $error("probe index past last entry");

    a_scan_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_out_valid)
        else $error("result pending during scan");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == OP_ENQ) && (r_count == FULL_COUNT)) |=>
            ($stable(r_count) && (r_out_status == ST_FULL)))
        else $error("enqueue to full queue changed count");

    a_lookup_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && !r_del) |=> $stable(r_count))
        else $error("lookup changed count");

endmodule

>>> sim/tb_searchable_fifo_queue_top.sv
// Self-checking stream testbench for the searchable FIFO queue: directed, then random.
module tb_searchable_fifo_queue_top;
    import sfq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int unsigned PHASE_ITEMS = 115;
    localparam int unsigned PHASE_COUNT = 10;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned MAX_PRINTS = 40;

    typedef struct {
        t_op                      op;
        logic [IO_VALUE_WIDTH-1:0] value;
    } t_queue_request;

    typedef struct {
        t_status                   status;
        logic [IO_VALUE_WIDTH-1:0] value_out;
    } t_queue_response;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IO_VALUE_WIDTH-1:0] s_axis_tdata = '0;   // value
    logic [OP_WIDTH-1:0]       s_axis_tuser = '0;   // op
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [IO_VALUE_WIDTH-1:0] m_axis_tdata;        // value_out
    logic [STATUS_WIDTH-1:0]   m_axis_tuser;        // status

    t_queue_request            request_q[$];
    t_queue_response           response_q[$];
    logic [IO_VALUE_WIDTH-1:0] held_values[$];
    logic [IO_VALUE_WIDTH-1:0] value_pool[8];

    int unsigned error_count = 0;
    int unsigned op_count[4] = '{0, 0, 0, 0};
    int unsigned full_count = 0;
    int unsigned miss_count = 0;
    int unsigned peak_fill = 0;
    int unsigned checked_count = 0;
    int unsigned source_gap = 0;
    int unsigned sink_gap = 0;
    bit          steady_flow = 1'b0;

    searchable_fifo_queue_top #(
        .DEPTH       (QUEUE_DEPTH),
        .VALUE_WIDTH (IO_VALUE_WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        error_count++;
    endtask

    task automatic add_request(input t_op op, input logic [IO_VALUE_WIDTH-1:0] value);
        t_queue_request req;
        req.op = op;
        req.value = value;
        request_q.push_back(req);
    endtask

    function automatic void predict_queue_op(input t_op op,
                                             input logic [IO_VALUE_WIDTH-1:0] value);
        t_queue_response rsp;
        int              hit;
        rsp.status = ST_EMPTY;
        rsp.value_out = '0;
        hit = -1;
        case (op)
            OP_ENQ: begin
                if (held_values.size() >= QUEUE_DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    held_values.push_back(value);
                    rsp.status = ST_OK;
                end
            end
            OP_DEQ: begin
                if (held_values.size() > 0) begin
                    rsp.value_out = held_values.pop_front();
                    rsp.status = ST_OK;
                end
            end
            default: begin
                foreach (held_values[i]) begin
                    if (hit < 0 && held_values[i] == value) begin
                        hit = i;
                    end
                end
                if (hit >= 0) begin
                    rsp.status = ST_OK;
                    if (op == OP_DEL) begin
                        held_values.delete(hit);
                    end
                end
            end
        endcase
        op_count[op]++;
        if (rsp.status == ST_FULL) full_count++;
        if (rsp.status == ST_EMPTY) miss_count++;
        if (held_values.size() > peak_fill) peak_fill = held_values.size();
        response_q.push_back(rsp);
    endfunction

    // Source side: hold each transfer until accepted, then pick the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_queue_op(t_op'(s_axis_tuser), s_axis_tdata);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (source_gap > 0) begin
                    source_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= request_q[0].op;
                    s_axis_tdata <= request_q[0].value;
                    void'(request_q.pop_front());
                    if (!steady_flow && $urandom_range(0, 5) == 0) begin
                        source_gap = $urandom_range(1, 11);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: check each result transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (response_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d value %h",
                                              m_axis_tuser, m_axis_tdata));
                end else begin
                    if (m_axis_tuser !== response_q[0].status) begin
                        report_mismatch($sformatf("status %0d, want %s", m_axis_tuser,
                                                  response_q[0].status.name()));
                    end
                    if (m_axis_tdata !== response_q[0].value_out) begin
                        report_mismatch($sformatf("value_out %h, want %h", m_axis_tdata,
                                                  response_q[0].value_out));
                    end
                    void'(response_q.pop_front());
                    checked_count++;
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!steady_flow && $urandom_range(0, 7) == 0) begin
                    sink_gap = $urandom_range(1, 11);
                end
            end
        end
    end

    task automatic wait_until_quiet();
        while (request_q.size() > 0 || s_axis_tvalid || response_q.size() > 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [IO_VALUE_WIDTH-1:0] pick_value();
        if ($urandom_range(0, 99) < 85) begin
            return value_pool[$urandom_range(0, 7)];
        end
        return $urandom;
    endfunction

    initial begin
        int unsigned              roll;
        int unsigned              enq_cut;
        int unsigned              deq_cut;
        int unsigned              look_cut;
        int unsigned              waited;
        t_op                      op;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty queue: dequeue, lookup and delete all miss; then enqueue, probe and delete.
        add_request(OP_DEQ, 32'hFFFF_FFFF);
        add_request(OP_LOOK, 32'h0000_0000);
        add_request(OP_DEL, 32'h0000_0000);
        add_request(OP_ENQ, 32'h8000_0000);
        add_request(OP_ENQ, 32'h7FFF_FFFF);
        add_request(OP_ENQ, 32'h0000_0000);
        add_request(OP_ENQ, 32'hFFFF_FFFF);
        add_request(OP_ENQ, 32'h0000_0005);
        add_request(OP_ENQ, 32'h0000_0009);
        add_request(OP_ENQ, 32'h0000_0005);
        add_request(OP_LOOK, 32'hFFFF_FFFF);
        add_request(OP_LOOK, 32'h0000_0007);
        add_request(OP_LOOK, 32'h0000_0005);
        add_request(OP_DEL, 32'h0000_0005);
        add_request(OP_DEL, 32'h8000_0000);
        add_request(OP_DEL, 32'h0000_0007);
        add_request(OP_DEQ, 32'h0000_0000);
        add_request(OP_DEQ, 32'h5555_AAAA);
        add_request(OP_LOOK, 32'h0000_0005);
        add_request(OP_DEL, 32'h0000_0005);
        add_request(OP_LOOK, 32'h0000_0005);
        wait_until_quiet();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            foreach (value_pool[i]) begin
                value_pool[i] = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 15))
                                                            : 32'($urandom);
            end
            value_pool[$urandom_range(0, 7)] = ($urandom_range(0, 1) == 0) ? 32'h8000_0000
                                                                          : 32'h7FFF_FFFF;
            case (phase % 3)
                0:       begin enq_cut = 70; deq_cut = 80; look_cut = 90; end
                1:       begin enq_cut = 20; deq_cut = 55; look_cut = 75; end
                default: begin enq_cut = 40; deq_cut = 55; look_cut = 75; end
            endcase
            steady_flow = (phase == PHASE_COUNT - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < enq_cut)       op = OP_ENQ;
                else if (roll < deq_cut)  op = OP_DEQ;
                else if (roll < look_cut) op = OP_LOOK;
                else                      op = OP_DEL;
                add_request(op, (op == OP_DEQ) ? 32'($urandom) : pick_value());
            end
            // Let all requests and results drain before the next phase.
            wait_until_quiet();
        end

        waited = 0;
        while (response_q.size() > 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (response_q.size() > 0) begin
            report_mismatch($sformatf("%0d results never arrived", response_q.size()));
        end

        $display("covered %0d enqueue, %0d dequeue, %0d lookup, %0d delete transfers",
                 op_count[OP_ENQ], op_count[OP_DEQ], op_count[OP_LOOK], op_count[OP_DEL]);
        $display("%0d full, %0d empty or miss, peak fill %0d, %0d results checked",
                 full_count, miss_count, peak_fill, checked_count);
        if (error_count == 0) begin
            $display("tb_searchable_fifo_queue_top passed");
        end else begin
            $display("tb_searchable_fifo_queue_top failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_searchable_fifo_queue_top failed");
        $finish;
    end

endmodule

>>> files.f
rtl/sfq_pkg.sv
rtl/sfq_cell.sv
rtl/sfq_chain.sv
rtl/searchable_fifo_queue_top.sv
sim/tb_searchable_fifo_queue_top.sv
